FILE: rtl/ubx_pkg.sv
// ubx_pkg: shared types and constants of the navigation frame parser
// parse phases, register indexes, watch configuration and result item layout
// no dependencies

package ubx_pkg;

  // sync pair that opens every frame
  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  // configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // reset values of the watch registers
  localparam logic [7:0] WatchClassRst  = 8'h01;
  localparam logic [7:0] WatchIdFirstRst  = 8'h07;
  localparam logic [7:0] WatchIdSecondRst = 8'h12;
  localparam logic [7:0] WatchIdThirdRst  = 8'h09;

  // all three watched messages seen
  localparam logic [2:0] SeenAll = 3'b111;

  // parser phases
  typedef enum logic [3:0] {
    PhSync1   = 4'd0,
    PhSync2   = 4'd1,
    PhClass   = 4'd2,
    PhId      = 4'd3,
    PhLenLo   = 4'd4,
    PhLenHi   = 4'd5,
    PhPayload = 4'd6,
    PhCkA     = 4'd7,
    PhCkB     = 4'd8
  } phase_e;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgWatchClass    = 3'd0,
    CfgWatchIdFirst  = 3'd1,
    CfgWatchIdSecond = 3'd2,
    CfgWatchIdThird  = 3'd3
  } cfg_idx_e;

  // which watched message a frame matched
  typedef enum logic [1:0] {
    KindOther  = 2'd0,
    KindFirst  = 2'd1,
    KindSecond = 2'd2,
    KindThird  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] watch_class;
    logic [7:0] watch_id_first;
    logic [7:0] watch_id_second;
    logic [7:0] watch_id_third;
  } watch_cfg_t;

  typedef struct packed {
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic        frame_status;
    kind_e       message_kind;
    logic        set_complete;
  } result_t;

endpackage

FILE: rtl/ubx_cfg_regs.sv
// ubx_cfg_regs: watch class and id registers behind the plain write port
// depends on ubx_pkg for register indexes, reset values and watch_cfg_t

module ubx_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ubx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ubx_pkg::CfgDataW-1:0]  cfg_data_i,
  output ubx_pkg::watch_cfg_t           cfg_o
);

  ubx_pkg::watch_cfg_t cfg_q, cfg_d;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ubx_pkg::cfg_idx_e'(cfg_index_i))
        ubx_pkg::CfgWatchClass:    cfg_d.watch_class     = cfg_data_i;
        ubx_pkg::CfgWatchIdFirst:  cfg_d.watch_id_first  = cfg_data_i;
        ubx_pkg::CfgWatchIdSecond: cfg_d.watch_id_second = cfg_data_i;
        ubx_pkg::CfgWatchIdThird:  cfg_d.watch_id_third  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.watch_class     <= ubx_pkg::WatchClassRst;
      cfg_q.watch_id_first  <= ubx_pkg::WatchIdFirstRst;
      cfg_q.watch_id_second <= ubx_pkg::WatchIdSecondRst;
      cfg_q.watch_id_third  <= ubx_pkg::WatchIdThirdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ubx_frame_fsm.sv
// ubx_frame_fsm: frame state machine, fletcher sums and watched-set tracking
// depends on ubx_pkg for phases, sync bytes, watch_cfg_t and result_t

module ubx_frame_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_accept_i,
  input  logic [7:0]          rx_byte_i,
  input  ubx_pkg::watch_cfg_t cfg_i,
  output logic                at_frame_end_o,
  output logic                res_valid_o,
  output ubx_pkg::result_t    res_o
);

  ubx_pkg::phase_e phase_q, phase_d;
  logic [7:0]  held_class_q, held_class_d;
  logic [7:0]  held_id_q, held_id_d;
  logic [15:0] held_length_q, held_length_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  rx_sum_a_q, rx_sum_a_d;
  logic [2:0]  seen_q, seen_d;

  logic [7:0]      sum_a_inc, sum_b_inc;
  logic [15:0]     len_full;
  logic            good;
  ubx_pkg::kind_e  kind;
  logic [2:0]      seen_upd;

  // running fletcher sums with the current item folded in
  assign sum_a_inc = sum_a_q + rx_byte_i;
  assign sum_b_inc = sum_b_q + sum_a_inc;
  assign len_full  = {rx_byte_i, held_length_q[7:0]};

  // checksum compare and watched message match, first position wins
  always_comb begin
    good = (rx_sum_a_q == sum_a_q) && (rx_byte_i == sum_b_q);
    kind = ubx_pkg::KindOther;
    if (good && (held_class_q == cfg_i.watch_class)) begin
      if (held_id_q == cfg_i.watch_id_first) begin
        kind = ubx_pkg::KindFirst;
      end else if (held_id_q == cfg_i.watch_id_second) begin
        kind = ubx_pkg::KindSecond;
      end else if (held_id_q == cfg_i.watch_id_third) begin
        kind = ubx_pkg::KindThird;
      end
    end
    case (kind)
      ubx_pkg::KindFirst:  seen_upd = seen_q | 3'b001;
      ubx_pkg::KindSecond: seen_upd = seen_q | 3'b010;
      ubx_pkg::KindThird:  seen_upd = seen_q | 3'b100;
      default:             seen_upd = seen_q;
    endcase
  end

  // next state and result
  always_comb begin
    phase_d       = phase_q;
    held_class_d  = held_class_q;
    held_id_d     = held_id_q;
    held_length_d = held_length_q;
    bytes_left_d  = bytes_left_q;
    sum_a_d       = sum_a_q;
    sum_b_d       = sum_b_q;
    rx_sum_a_d    = rx_sum_a_q;
    seen_d        = seen_q;
    res_valid_o   = 1'b0;
    res_o.frame_class  = held_class_q;
    res_o.frame_id     = held_id_q;
    res_o.frame_length = held_length_q;
    res_o.frame_status = ~good;
    res_o.message_kind = kind;
    res_o.set_complete = 1'b0;
    if (byte_accept_i) begin
      case (phase_q)
        ubx_pkg::PhSync2: begin
          if (rx_byte_i == ubx_pkg::SyncSecond) begin
            phase_d = ubx_pkg::PhClass;
            sum_a_d = '0;
            sum_b_d = '0;
          end else if (rx_byte_i != ubx_pkg::SyncFirst) begin
            phase_d = ubx_pkg::PhSync1;
          end
        end
        ubx_pkg::PhClass: begin
          held_class_d = rx_byte_i;
          sum_a_d      = sum_a_inc;
          sum_b_d      = sum_b_inc;
          phase_d      = ubx_pkg::PhId;
        end
        ubx_pkg::PhId: begin
          held_id_d = rx_byte_i;
          sum_a_d   = sum_a_inc;
          sum_b_d   = sum_b_inc;
          phase_d   = ubx_pkg::PhLenLo;
        end
        ubx_pkg::PhLenLo: begin
          held_length_d = {8'h00, rx_byte_i};
          sum_a_d       = sum_a_inc;
          sum_b_d       = sum_b_inc;
          phase_d       = ubx_pkg::PhLenHi;
        end
        ubx_pkg::PhLenHi: begin
          held_length_d = len_full;
          bytes_left_d  = len_full;
          sum_a_d       = sum_a_inc;
          sum_b_d       = sum_b_inc;
          phase_d       = (len_full == 16'd0) ? ubx_pkg::PhCkA : ubx_pkg::PhPayload;
        end
        ubx_pkg::PhPayload: begin
          sum_a_d      = sum_a_inc;
          sum_b_d      = sum_b_inc;
          bytes_left_d = bytes_left_q - 16'd1;
          if (bytes_left_q == 16'd1) begin
            phase_d = ubx_pkg::PhCkA;
          end
        end
        ubx_pkg::PhCkA: begin
          rx_sum_a_d = rx_byte_i;
          phase_d    = ubx_pkg::PhCkB;
        end
        ubx_pkg::PhCkB: begin
          res_valid_o = 1'b1;
          seen_d      = seen_upd;
          if (seen_upd == ubx_pkg::SeenAll) begin
            res_o.set_complete = 1'b1;
            seen_d             = '0;
          end
          phase_d = ubx_pkg::PhSync1;
        end
        // hunting, unknown codes hunt too
        default: begin
          phase_d = (rx_byte_i == ubx_pkg::SyncFirst) ? ubx_pkg::PhSync2
                                                      : ubx_pkg::PhSync1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= ubx_pkg::PhSync1;
      held_class_q  <= '0;
      held_id_q     <= '0;
      held_length_q <= '0;
      bytes_left_q  <= '0;
      sum_a_q       <= '0;
      sum_b_q       <= '0;
      rx_sum_a_q    <= '0;
      seen_q        <= '0;
    end else begin
      phase_q       <= phase_d;
      held_class_q  <= held_class_d;
      held_id_q     <= held_id_d;
      held_length_q <= held_length_d;
      bytes_left_q  <= bytes_left_d;
      sum_a_q       <= sum_a_d;
      sum_b_q       <= sum_b_d;
      rx_sum_a_q    <= rx_sum_a_d;
      seen_q        <= seen_d;
    end
  end

  assign at_frame_end_o = (phase_q == ubx_pkg::PhCkB);

`ifndef SYNTH
  // payload phase always has bytes still to come
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ubx_pkg::PhPayload) |-> (bytes_left_q != 16'd0))
    else $error("payload phase with no bytes left");

  // the mask is cleared as soon as it fills
  a_seen_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != ubx_pkg::SeenAll)
    else $error("seen mask left full");

  // a frame end always returns to hunting
  a_end_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_accept_i && at_frame_end_o) |=> (phase_q == ubx_pkg::PhSync1))
    else $error("no resync after frame end");

  // a completed set only comes with a good watched frame
  a_complete_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.set_complete) |->
      (!res_o.frame_status && (res_o.message_kind != ubx_pkg::KindOther)))
    else $error("set complete on bad or unwatched frame");
`endif

endmodule

FILE: rtl/ubx_result_reg.sv
// ubx_result_reg: output register holding one result item for the receiver
// depends on ubx_pkg for result_t

module ubx_result_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ubx_pkg::result_t data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output ubx_pkg::result_t data_o
);

  logic             valid_q, valid_d;
  ubx_pkg::result_t data_q;

  // valid sets on load, clears when taken without a new load
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

`ifndef SYNTH
  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || out_ready_i))
    else $error("pending result overwritten");
`endif

endmodule

FILE: rtl/ubx_frame_parser_core.sv
// ubx_frame_parser_core: top level of the binary navigation frame parser
// depends on ubx_pkg, ubx_cfg_regs, ubx_frame_fsm and ubx_result_reg
//
// usage:
//   input channel  in_valid_i / in_ready_o carries one received byte per item
//   output channel out_valid_o / out_ready_i carries one frame report per
//   completed frame (class, id, length, checksum status, watched kind, set flag)
//   config port    cfg_we_i / cfg_index_i / cfg_data_i writes the watch class
//   and three watch ids, one register per cycle, no read-back
// throughput: one byte per cycle unless stalled; the frame state machine and
//   fletcher sums update in the cycle the byte is taken
// output: a report appears on the output in the cycle after the second checksum
//   byte is accepted, from a single output register
// stall: while the report register is full and not being taken, bytes that
//   finish no frame are still accepted; only a second checksum byte waits
// reset: parser hunts for the first sync byte, sums and watched mask cleared,
//   watch registers return to their defaults, output empty

module ubx_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ubx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ubx_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    frame_class_o,
  output logic [7:0]                    frame_id_o,
  output logic [15:0]                   frame_length_o,
  output logic                          frame_status_o,
  output logic [1:0]                    message_kind_o,
  output logic                          set_complete_o
);

  ubx_pkg::watch_cfg_t cfg;
  ubx_pkg::result_t    res, res_out;
  logic                res_valid;
  logic                at_frame_end;
  logic                byte_accept;

  ubx_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // a frame-ending byte needs room in the output register
  assign in_ready_o  = !at_frame_end || !out_valid_o || out_ready_i;
  assign byte_accept = in_valid_i && in_ready_o;

  ubx_frame_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_accept_i (byte_accept),
    .rx_byte_i     (rx_byte_i),
    .cfg_i         (cfg),
    .at_frame_end_o(at_frame_end),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ubx_result_reg u_res (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .data_i     (res),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .data_o     (res_out)
  );

  // unpack the report onto its ports
  assign frame_class_o  = res_out.frame_class;
  assign frame_id_o     = res_out.frame_id;
  assign frame_length_o = res_out.frame_length;
  assign frame_status_o = res_out.frame_status;
  assign message_kind_o = res_out.message_kind;
  assign set_complete_o = res_out.set_complete;

endmodule
